// ===== src/hsl2rgb_pkg.sv =====
package hsl2rgb_pkg;

    // Segment of the piecewise-linear hue ramp that a channel falls in
    typedef enum logic [1:0] {
        RAMP_UP,
        RAMP_HIGH,
        RAMP_DOWN,
        RAMP_LOW
    } ramp_sel_t;

    localparam int NUM_CHAN = 3;
    localparam int CHAN_RED = 0;
    localparam int CHAN_GREEN = 1;
    localparam int CHAN_BLUE = 2;

endpackage

// ===== src/hsl_to_rgb_converter.sv =====
// An accepted input word passes through the stage 1 to 4 registers, then the output register.
// Throughput: one pixel per clock while m_tready does not stall the output; the saturation
// product and the three ramp products each have a multiplier of their own, in stages 2 and 4.
// A stall at the output backs up stage by stage, so bubbles are absorbed.
// Reset (rst_n low, asynchronous) clears every stage valid bit; payload
// registers are not reset.
module hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic s_tvalid,
    output logic s_tready,
    // hue [FRAC_BITS-1:0], saturation [FRAC_BITS+1 bits], lightness [FRAC_BITS+1 bits]
    input  logic [((3*FRAC_BITS+2+7)/8)*8-1:0] s_tdata,

    output logic m_tvalid,
    input  logic m_tready,
    // red [FRAC_BITS+1 bits], green [FRAC_BITS+1 bits], blue [FRAC_BITS+1 bits]
    output logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0] m_tdata
);

    localparam int W = FRAC_BITS;
    localparam int OUT_W = ((3*(FRAC_BITS+1)+7)/8)*8;

    localparam logic [W:0]   ONE       = {1'b1, {W{1'b0}}};
    localparam logic [W-1:0] SIXTH     = W'(ONE / 6);
    localparam logic [W-1:0] THIRD     = W'(ONE / 3);
    localparam logic [W-1:0] HALF      = W'(ONE / 2);
    localparam logic [W-1:0] TWO_THIRD = W'((2 * ONE) / 3);

    function automatic ramp_sel_t ramp_select(input logic [W-1:0] t);
        ramp_sel_t sel;
        if (t < SIXTH)
            sel = RAMP_UP;
        else if (t < HALF)
            sel = RAMP_HIGH;
        else if (t < TWO_THIRD)
            sel = RAMP_DOWN;
        else
            sel = RAMP_LOW;
        return sel;
    endfunction

    // Slope factor 6*t on the rising edge, 6*(2/3 - t) on the falling edge
    function automatic logic [W:0] ramp_factor(input logic [W-1:0] t);
        logic [W-1:0] base;
        logic [W+2:0] six;
        if (t < SIXTH)
            base = t;
        else if (t >= HALF && t < TWO_THIRD)
            base = TWO_THIRD - t;
        else
            base = '0;
        six = {1'b0, base, 2'b00} + {2'b00, base, 1'b0};
        return six[W:0];
    endfunction

    // Stage handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic ready1, ready2, ready3, ready4, ready5;

    assign ready5 = !out_valid_reg || m_tready;
    assign ready4 = !s4_valid_reg || ready5;
    assign ready3 = !s3_valid_reg || ready4;
    assign ready2 = !s2_valid_reg || ready3;
    assign ready1 = !s1_valid_reg || ready2;
    assign s_tready = ready1;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                s1_valid_reg <= s_tvalid;
            if (ready2)
                s2_valid_reg <= s1_valid_reg;
            if (ready3)
                s3_valid_reg <= s2_valid_reg;
            if (ready4)
                s4_valid_reg <= s3_valid_reg;
            if (ready5)
                out_valid_reg <= s4_valid_reg;
        end
    end

    // Stage 1: clamp inputs, place hue on each channel's ramp
    logic [W-1:0] in_hue;
    logic [W:0]   in_sat, in_lit;
    logic [W-1:0] chan_t [NUM_CHAN];
    logic [W:0]   s1_sat_next, s1_lit_next;

    assign in_hue = s_tdata[W-1:0];
    assign in_sat = s_tdata[2*W:W];
    assign in_lit = s_tdata[3*W+1:2*W+1];

    assign s1_sat_next = (in_sat > ONE) ? ONE : in_sat;
    assign s1_lit_next = (in_lit > ONE) ? ONE : in_lit;

    assign chan_t[CHAN_RED]   = in_hue + THIRD;
    assign chan_t[CHAN_GREEN] = in_hue;
    assign chan_t[CHAN_BLUE]  = in_hue - THIRD;

    logic [W:0]  s1_sat_reg, s1_lit_reg;
    logic        s1_gray_reg;
    ramp_sel_t   s1_sel_reg [NUM_CHAN];
    logic [W:0]  s1_fac_reg [NUM_CHAN];

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            s1_sat_reg  <= s1_sat_next;
            s1_lit_reg  <= s1_lit_next;
            s1_gray_reg <= (s1_sat_next == '0);
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                s1_sel_reg[c] <= ramp_select(chan_t[c]);
                s1_fac_reg[c] <= ramp_factor(chan_t[c]);
            end
        end
    end

    // Stage 2: l*s
    logic [2*W+1:0] ls_prod;
    assign ls_prod = s1_lit_reg * s1_sat_reg;

    logic [W:0]  s2_sat_reg, s2_lit_reg, s2_ls_reg;
    logic        s2_gray_reg;
    ramp_sel_t   s2_sel_reg [NUM_CHAN];
    logic [W:0]  s2_fac_reg [NUM_CHAN];

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            s2_sat_reg  <= s1_sat_reg;
            s2_lit_reg  <= s1_lit_reg;
            s2_ls_reg   <= ls_prod[2*W:W];
            s2_gray_reg <= s1_gray_reg;
            s2_sel_reg  <= s1_sel_reg;
            s2_fac_reg  <= s1_fac_reg;
        end
    end

    // Stage 3: q, p and the ramp height q - p
    logic [W+1:0]        s3_q_next;
    logic signed [W+2:0] s3_p_next, diff;
    logic [W+1:0]        s3_ud_next;

    always_comb
    begin
        if ({1'b0, s2_lit_reg} < {2'b00, HALF})
            s3_q_next = {1'b0, s2_lit_reg} + {1'b0, s2_ls_reg};
        else
            s3_q_next = {1'b0, s2_lit_reg} + {1'b0, s2_sat_reg} - {1'b0, s2_ls_reg};
        s3_p_next = $signed({1'b0, s2_lit_reg, 1'b0}) - $signed({1'b0, s3_q_next});
        diff = $signed({1'b0, s3_q_next}) - s3_p_next;
        s3_ud_next = diff[W+2] ? '0 : diff[W+1:0];
    end

    logic [W+1:0]        s3_q_reg, s3_ud_reg;
    logic signed [W+2:0] s3_p_reg;
    logic [W:0]          s3_lit_reg;
    logic                s3_gray_reg;
    ramp_sel_t           s3_sel_reg [NUM_CHAN];
    logic [W:0]          s3_fac_reg [NUM_CHAN];

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            s3_q_reg    <= s3_q_next;
            s3_p_reg    <= s3_p_next;
            s3_ud_reg   <= s3_ud_next;
            s3_lit_reg  <= s2_lit_reg;
            s3_gray_reg <= s2_gray_reg;
            s3_sel_reg  <= s2_sel_reg;
            s3_fac_reg  <= s2_fac_reg;
        end
    end

    // Stage 4: ramp products, one multiplier per channel
    logic [2*W+2:0] ramp_prod [NUM_CHAN];

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
            ramp_prod[c] = s3_ud_reg * s3_fac_reg[c];
    end

    logic [W+1:0]        s4_q_reg;
    logic signed [W+2:0] s4_p_reg;
    logic [W:0]          s4_lit_reg;
    logic                s4_gray_reg;
    ramp_sel_t           s4_sel_reg [NUM_CHAN];
    logic [W+1:0]        s4_ramp_reg [NUM_CHAN];

    always_ff @(posedge clk)
    begin
        if (ready4)
        begin
            s4_q_reg    <= s3_q_reg;
            s4_p_reg    <= s3_p_reg;
            s4_lit_reg  <= s3_lit_reg;
            s4_gray_reg <= s3_gray_reg;
            s4_sel_reg  <= s3_sel_reg;
            for (int c = 0; c < NUM_CHAN; c++)
                s4_ramp_reg[c] <= ramp_prod[c][2*W+1:W];
        end
    end

    // Stage 5: pick the segment value, clamp to 0..1, gray bypass
    logic signed [W+3:0] p_ext, q_ext, chan_v [NUM_CHAN];
    logic [W:0]          chan_next [NUM_CHAN];

    assign p_ext = {s4_p_reg[W+2], s4_p_reg};
    assign q_ext = $signed({2'b00, s4_q_reg});

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            case (s4_sel_reg[c])
                RAMP_UP, RAMP_DOWN: chan_v[c] = p_ext + $signed({2'b00, s4_ramp_reg[c]});
                RAMP_HIGH:          chan_v[c] = q_ext;
                RAMP_LOW:           chan_v[c] = p_ext;
                default:            chan_v[c] = p_ext;
            endcase
            if (s4_gray_reg)
                chan_next[c] = s4_lit_reg;
            else if (chan_v[c][W+3])
                chan_next[c] = '0;
            else if (chan_v[c] > $signed({3'b000, ONE}))
                chan_next[c] = ONE;
            else
                chan_next[c] = chan_v[c][W:0];
        end
    end

    logic [W:0] out_red_reg, out_green_reg, out_blue_reg;

    always_ff @(posedge clk)
    begin
        if (ready5)
        begin
            out_red_reg   <= chan_next[CHAN_RED];
            out_green_reg <= chan_next[CHAN_GREEN];
            out_blue_reg  <= chan_next[CHAN_BLUE];
        end
    end

    assign m_tdata = OUT_W'({out_blue_reg, out_green_reg, out_red_reg});

    a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> s1_valid_reg)
        else $error("accepted word did not enter stage 1");

    a_s1_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_sat_reg <= ONE && s1_lit_reg <= ONE))
        else $error("stage 1 saturation or lightness above one");

    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && ready5 && s4_gray_reg) |=>
            (out_red_reg == out_green_reg && out_green_reg == out_blue_reg))
        else $error("gray pixel with unequal channels");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_red_reg <= ONE && out_green_reg <= ONE && out_blue_reg <= ONE))
        else $error("output channel above one");

endmodule
